[hw/rtl/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types, widths and register indexes of the ray/sphere intersect core.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // Datapath widths
    localparam int COORD_W = 16;              // Q8.8 coordinate
    localparam int RADIUS_W = 15;             // unsigned Q7.8 radius
    localparam int DIFF_W = COORD_W + 1;      // origin minus center
    localparam int A_W = 32;                  // a = D.D
    localparam int H_W = 34;                  // h = L.D, signed
    localparam int E_W = 35;                  // e = L.L - r*r, signed
    localparam int SQ_W = 66;                 // h*h and a*|e|
    localparam int RAD_W = 68;                // radicand, even width
    localparam int ROOT_W = RAD_W / 2;        // square root
    localparam int REM_W = ROOT_W + 4;        // square root remainder
    localparam int NUM_W = 37;                // -h - sqrt(q), signed
    localparam int FRAC_W = 16;               // Q16.16 fraction bits
    localparam int DVD_W = NUM_W - 2 + FRAC_W; // dividend magnitude
    localparam int DIST_W = 32;               // result distance

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CENTER_X      = 2'd0,
        CFG_CENTER_Y      = 2'd1,
        CFG_CENTER_Z      = 2'd2,
        CFG_SPHERE_RADIUS = 2'd3
    } cfg_index_t;

    // Input beat
    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } ray_in_t;

    // Result beat
    typedef struct packed {
        logic                     hit;
        logic signed [DIST_W-1:0] hit_distance;
    } ray_out_t;

    // Side data carried alongside the square root
    typedef struct packed {
        logic                  hit;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
    } sqrt_side_t;

    // Side data carried alongside the divider
    typedef struct packed {
        logic hit;
        logic neg;
    } div_side_t;

endpackage

[hw/rtl/ray_sphere_intersect_core.sv]
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Ray against configured sphere; near hit distance in signed Q16.16.
// ----------------------------------------------------------------------------
// One ray beat enters on s_valid/s_ready (origin and direction, Q8.8) and one
// result beat leaves on m_valid/m_ready: hit flag and near root distance,
// saturated Q16.16, zero on a miss or tangent ray. The sphere center and
// radius are written through cfg_wr_en/cfg_addr/cfg_wdata; the user must
// write them only while no ray is in flight; the block does not enforce it.
// A write takes effect at once. Throughput is one ray per cycle while the
// output is not stalled. It has 6 set-up stages, 34 square root stages (one
// root bit each), 52 divide stages (numerator plus one quotient bit each)
// and the output register. The depth follows from the bit-per-stage root
// and divider. Reset clears all stage valid bits and m_valid and loads the
// center (0,0,0) and radius 1.0. When the receiver holds m_ready low with a
// result waiting, the whole pipeline holds and s_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_core
    import rsi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ray_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ray_out_t           m_data,
    input  logic               cfg_wr_en,
    input  cfg_index_t         cfg_addr,
    input  logic [COORD_W-1:0] cfg_wdata
);

    // Configuration registers
    logic signed [COORD_W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [RADIUS_W-1:0]       radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= RADIUS_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_CENTER_X:      center_x_reg <= cfg_wdata;
                CFG_CENTER_Y:      center_y_reg <= cfg_wdata;
                CFG_CENTER_Z:      center_z_reg <= cfg_wdata;
                CFG_SPHERE_RADIUS: radius_reg   <= cfg_wdata[RADIUS_W-1:0];
                default:           ;
            endcase
        end
    end

    // Advance everything when the output register is free or being drained
    logic en;
    logic m_valid_reg;
    ray_out_t m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic       fr_valid;
    sqrt_side_t fr_side;
    logic [RAD_W-1:0] fr_rad;

    rsi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .ray       (s_data),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .radius    (radius_reg),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_rad   (fr_rad)
    );

    logic              sq_valid;
    sqrt_side_t        sq_side;
    logic [ROOT_W-1:0] sq_root;

    rsi_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_rad    (fr_rad),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    logic             dv_valid;
    div_side_t        dv_side;
    logic [DVD_W-1:0] dv_quo;

    rsi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    // Apply sign and saturate to Q16.16
    localparam logic [DVD_W-1:0] NEG_LIMIT = DVD_W'(1) << (DIST_W-1);
    localparam logic [DVD_W-1:0] POS_LIMIT = (DVD_W'(1) << (DIST_W-1)) - DVD_W'(1);

    logic [DIST_W-1:0] dist_sat;

    always_comb begin
        if (!dv_side.hit) begin
            dist_sat = '0;
        end else if (dv_side.neg) begin
            dist_sat = (dv_quo > NEG_LIMIT) ? NEG_LIMIT[DIST_W-1:0] : -dv_quo[DIST_W-1:0];
        end else begin
            dist_sat = (dv_quo > POS_LIMIT) ? POS_LIMIT[DIST_W-1:0] : dv_quo[DIST_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.hit          <= dv_side.hit;
            m_data_reg.hit_distance <= dist_sat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/rsi_front.sv]
// ----------------------------------------------------------------------------
// rsi_front
// Quadratic set-up: a, h, e, split wide products and the quarter discriminant.
// ----------------------------------------------------------------------------
module rsi_front
    import rsi_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  ray_in_t                    ray,
    input  logic signed [COORD_W-1:0]  center_x,
    input  logic signed [COORD_W-1:0]  center_y,
    input  logic signed [COORD_W-1:0]  center_z,
    input  logic [RADIUS_W-1:0]        radius,
    output logic                       out_valid,
    output sqrt_side_t                 out_side,
    output logic [RAD_W-1:0]           out_rad
);

    localparam int LO_W = 17;
    localparam int HM_W = H_W - 1;
    localparam int EM_W = E_W - 1;

    // Stage 1: offsets from center
    logic                      v1_reg;
    logic signed [DIFF_W-1:0]  lx1_reg, ly1_reg, lz1_reg;
    logic signed [COORD_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic [RADIUS_W-1:0]       r1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lx1_reg <= DIFF_W'(ray.origin_x) - DIFF_W'(center_x);
            ly1_reg <= DIFF_W'(ray.origin_y) - DIFF_W'(center_y);
            lz1_reg <= DIFF_W'(ray.origin_z) - DIFF_W'(center_z);
            dx1_reg <= ray.dir_x;
            dy1_reg <= ray.dir_y;
            dz1_reg <= ray.dir_z;
            r1_reg  <= radius;
        end
    end

    // Stage 2: element products
    logic                              v2_reg;
    logic signed [2*COORD_W-1:0]       ax2_reg, ay2_reg, az2_reg;
    logic signed [DIFF_W+COORD_W-1:0]  hx2_reg, hy2_reg, hz2_reg;
    logic signed [2*DIFF_W-1:0]        ex2_reg, ey2_reg, ez2_reg;
    logic [2*RADIUS_W-1:0]             rr2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax2_reg <= (2*COORD_W)'(dx1_reg) * (2*COORD_W)'(dx1_reg);
            ay2_reg <= (2*COORD_W)'(dy1_reg) * (2*COORD_W)'(dy1_reg);
            az2_reg <= (2*COORD_W)'(dz1_reg) * (2*COORD_W)'(dz1_reg);
            hx2_reg <= (DIFF_W+COORD_W)'(lx1_reg) * (DIFF_W+COORD_W)'(dx1_reg);
            hy2_reg <= (DIFF_W+COORD_W)'(ly1_reg) * (DIFF_W+COORD_W)'(dy1_reg);
            hz2_reg <= (DIFF_W+COORD_W)'(lz1_reg) * (DIFF_W+COORD_W)'(dz1_reg);
            ex2_reg <= (2*DIFF_W)'(lx1_reg) * (2*DIFF_W)'(lx1_reg);
            ey2_reg <= (2*DIFF_W)'(ly1_reg) * (2*DIFF_W)'(ly1_reg);
            ez2_reg <= (2*DIFF_W)'(lz1_reg) * (2*DIFF_W)'(lz1_reg);
            rr2_reg <= (2*RADIUS_W)'(r1_reg) * (2*RADIUS_W)'(r1_reg);
        end
    end

    // Stage 3: sums a, h, e
    logic                  v3_reg;
    logic [A_W-1:0]        a3_reg;
    logic signed [H_W-1:0] h3_reg;
    logic signed [E_W-1:0] e3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg <= A_W'(ax2_reg) + A_W'(ay2_reg) + A_W'(az2_reg);
            h3_reg <= H_W'(hx2_reg) + H_W'(hy2_reg) + H_W'(hz2_reg);
            e3_reg <= E_W'(ex2_reg) + E_W'(ey2_reg) + E_W'(ez2_reg)
                      - $signed(E_W'(rr2_reg));
        end
    end

    // Stage 4: magnitudes and partial products of h*h and a*|e|
    logic [HM_W-1:0]       hm;
    logic [EM_W-1:0]       em;
    logic signed [H_W-1:0] h_neg;
    logic signed [E_W-1:0] e_neg;

    assign h_neg = -h3_reg;
    assign e_neg = -e3_reg;
    assign hm = h3_reg[H_W-1] ? HM_W'(h_neg) : HM_W'(h3_reg);
    assign em = e3_reg[E_W-1] ? EM_W'(e_neg) : EM_W'(e3_reg);

    logic                        v4_reg;
    logic                        epos4_reg;
    logic signed [H_W-1:0]       h4_reg;
    logic [A_W-1:0]              a4_reg;
    logic [HM_W+LO_W-1:0]        phl4_reg;
    logic [2*HM_W-LO_W-1:0]      phh4_reg;
    logic [A_W+LO_W-1:0]         pal4_reg;
    logic [A_W+EM_W-LO_W-1:0]    pah4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            epos4_reg <= !e3_reg[E_W-1] && (e3_reg != '0);
            h4_reg    <= h3_reg;
            a4_reg    <= a3_reg;
            phl4_reg  <= (HM_W+LO_W)'(hm) * (HM_W+LO_W)'(hm[LO_W-1:0]);
            phh4_reg  <= (2*HM_W-LO_W)'(hm) * (2*HM_W-LO_W)'(hm[HM_W-1:LO_W]);
            pal4_reg  <= (A_W+LO_W)'(a3_reg) * (A_W+LO_W)'(em[LO_W-1:0]);
            pah4_reg  <= (A_W+EM_W-LO_W)'(a3_reg) * (A_W+EM_W-LO_W)'(em[EM_W-1:LO_W]);
        end
    end

    // Stage 5: assemble the wide squares
    logic                  v5_reg;
    logic                  epos5_reg;
    logic signed [H_W-1:0] h5_reg;
    logic [A_W-1:0]        a5_reg;
    logic [SQ_W-1:0]       hh5_reg, ae5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            epos5_reg <= epos4_reg;
            h5_reg    <= h4_reg;
            a5_reg    <= a4_reg;
            hh5_reg   <= SQ_W'(phl4_reg) + (SQ_W'(phh4_reg) << LO_W);
            ae5_reg   <= SQ_W'(pal4_reg) + (SQ_W'(pah4_reg) << LO_W);
        end
    end

    // Stage 6: quarter discriminant and hit decision
    logic [RAD_W-1:0] qsum;

    assign qsum = epos5_reg ? (RAD_W'(hh5_reg) - RAD_W'(ae5_reg))
                            : (RAD_W'(hh5_reg) + RAD_W'(ae5_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_side.hit <= !qsum[RAD_W-1] && (qsum != '0) && (a5_reg != '0);
            out_side.h   <= h5_reg;
            out_side.a   <= a5_reg;
            out_rad      <= qsum;
        end
    end

endmodule

[hw/rtl/rsi_sqrt.sv]
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rsi_sqrt
    import rsi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sqrt_side_t        in_side,
    input  logic [RAD_W-1:0]  in_rad,
    output logic              out_valid,
    output sqrt_side_t        out_side,
    output logic [ROOT_W-1:0] out_root
);

    logic              v_reg    [ROOT_W];
    sqrt_side_t        side_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_in;
        sqrt_side_t        side_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_try;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Bring down two radicand bits and try root*4+1
        assign rem_try = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial   = REM_W'({root_in, 2'b01});
        assign take    = (rem_try >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_in;
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= take ? (rem_try - trial) : rem_try;
                root_reg[k] <= {root_in[ROOT_W-2:0], take};
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

[hw/rtl/rsi_div.sv]
// ----------------------------------------------------------------------------
// rsi_div
// Near-root numerator and pipelined restoring divide by a, one bit per stage.
// ----------------------------------------------------------------------------
module rsi_div
    import rsi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sqrt_side_t        in_side,
    input  logic [ROOT_W-1:0] in_root,
    output logic              out_valid,
    output div_side_t         out_side,
    output logic [DVD_W-1:0]  out_quo
);

    // Numerator -h - sqrt(q), split into sign and magnitude
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] num_neg;
    logic [NUM_W-2:0]        num_mag;

    assign num     = -NUM_W'(in_side.h) - $signed(NUM_W'(in_root));
    assign num_neg = -num;
    assign num_mag = num[NUM_W-1] ? (NUM_W-1)'(num_neg) : (NUM_W-1)'(num);

    logic             v0_reg;
    div_side_t        side0_reg;
    logic [A_W-1:0]   a0_reg;
    logic [DVD_W-1:0] dvd0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side0_reg.hit <= in_side.hit;
            side0_reg.neg <= num[NUM_W-1];
            a0_reg        <= in_side.a;
            dvd0_reg      <= {num_mag[NUM_W-3:0], {FRAC_W{1'b0}}};
        end
    end

    // Divide stages: dividend shifts out the top, quotient bits shift in
    logic             v_reg    [DVD_W];
    div_side_t        side_reg [DVD_W];
    logic [A_W-1:0]   a_reg    [DVD_W];
    logic [DVD_W-1:0] dvd_reg  [DVD_W];
    logic [A_W-1:0]   rem_reg  [DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        logic             v_in;
        div_side_t        side_in;
        logic [A_W-1:0]   a_in;
        logic [DVD_W-1:0] dvd_in;
        logic [A_W-1:0]   rem_in;
        logic [A_W:0]     rem_try;
        logic             take;

        if (k == 0) begin : g_first
            assign v_in    = v0_reg;
            assign side_in = side0_reg;
            assign a_in    = a0_reg;
            assign dvd_in  = dvd0_reg;
            assign rem_in  = '0;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
            assign a_in    = a_reg[k-1];
            assign dvd_in  = dvd_reg[k-1];
            assign rem_in  = rem_reg[k-1];
        end

        assign rem_try = {rem_in, dvd_in[DVD_W-1]};
        assign take    = (rem_try >= {1'b0, a_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_in;
                a_reg[k]    <= a_in;
                dvd_reg[k]  <= {dvd_in[DVD_W-2:0], take};
                rem_reg[k]  <= take ? A_W'(rem_try - {1'b0, a_in}) : A_W'(rem_try);
            end
        end
    end

    assign out_valid = v_reg[DVD_W-1];
    assign out_side  = side_reg[DVD_W-1];
    assign out_quo   = dvd_reg[DVD_W-1];

endmodule

[verif/ray_sphere_checker.sv]
// ----------------------------------------------------------------------------
// ray_sphere_checker
// Watches the ray and result channels and checks every result beat.
// ----------------------------------------------------------------------------
// For each accepted ray beat it computes the expected hit flag and near hit
// distance from its own copy of the sphere registers. It compares each
// accepted result beat, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module ray_sphere_checker
    import rsi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  ray_in_t            s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  ray_out_t           m_data,
    input  logic               cfg_wr_en,
    input  cfg_index_t         cfg_addr,
    input  logic [COORD_W-1:0] cfg_wdata,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [15:0] sph_cx = '0, sph_cy = '0, sph_cz = '0;
    logic [14:0]        sph_r = 15'd256;
    ray_out_t           expected_hits[$];

    // Floor square root of a nonnegative value below 2^68
    function automatic logic [33:0] floor_sqrt(logic [67:0] v);
        logic [33:0] root;
        logic [33:0] trial;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            if ({34'd0, trial} * {34'd0, trial} <= v) root = trial;
        end
        return root;
    endfunction

    // Expected result for one ray against the current sphere
    function automatic ray_out_t intersect_ray(ray_in_t ray);
        ray_out_t    res;
        logic signed [71:0] lx, ly, lz, dx, dy, dz, a, h, e, q, num, quo, rr;
        logic [71:0] mq;
        res = '0;
        lx = $signed(ray.origin_x) - sph_cx;
        ly = $signed(ray.origin_y) - sph_cy;
        lz = $signed(ray.origin_z) - sph_cz;
        dx = ray.dir_x;
        dy = ray.dir_y;
        dz = ray.dir_z;
        rr = $signed({1'b0, sph_r});
        a = dx * dx + dy * dy + dz * dz;
        h = lx * dx + ly * dy + lz * dz;
        e = lx * lx + ly * ly + lz * lz - rr * rr;
        q = h * h - a * e;
        if (q <= 0 || a == 0) return res;
        num = -h - $signed({38'd0, floor_sqrt(q[67:0])});
        mq = (num < 0) ? -num : num;
        mq = (mq << 16) / a;
        quo = (num < 0) ? -$signed(mq) : $signed(mq);
        if (quo > 72'sd2147483647) quo = 72'sd2147483647;
        if (quo < -72'sd2147483648) quo = -72'sd2147483648;
        res.hit = 1'b1;
        res.hit_distance = quo[31:0];
        return res;
    endfunction

    assign pending_count = expected_hits.size();

    always @(posedge aclk) begin
        ray_out_t want;
        if (!aresetn) begin
            sph_cx <= '0;
            sph_cy <= '0;
            sph_cz <= '0;
            sph_r  <= 15'd256;
            expected_hits.delete();
            fail_count <= 0;
        end else begin
            // Predict on ray beats, using registers before this edge's write
            if (s_valid && s_ready) expected_hits.push_back(intersect_ray(s_data));
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_CENTER_X:      sph_cx <= cfg_wdata;
                    CFG_CENTER_Y:      sph_cy <= cfg_wdata;
                    CFG_CENTER_Z:      sph_cz <= cfg_wdata;
                    CFG_SPHERE_RADIUS: sph_r  <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            // Compare result beats with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result beat hit=%0d dist=%0d",
                           m_data.hit, m_data.hit_distance);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_hits.pop_front();
                    if (m_data.hit !== want.hit) begin
                        $error("hit: expected %0d actual %0d", want.hit, m_data.hit);
                        fail_count <= fail_count + 1;
                    end else if (m_data.hit_distance !== want.hit_distance) begin
                        $error("hit_distance: expected %0d actual %0d",
                               want.hit_distance, m_data.hit_distance);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/tb_ray_sphere_intersect_core.sv]
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect_core
// Stimulus and verdict for the ray/sphere intersect core.
// ----------------------------------------------------------------------------
// Drives directed and random rays over several sphere settings and idling
// phases, including a long output stall; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect_core;
    import rsi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 93;
    localparam int WATCHDOG_LIMIT = 4000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ray_in_t            s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ray_out_t           m_data;
    logic               cfg_wr_en = 1'b0;
    cfg_index_t         cfg_addr = CFG_CENTER_X;
    logic [COORD_W-1:0] cfg_wdata = '0;
    int                 fail_count;
    int                 pending_count;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_off_cycles = 0;
    int                 quiet_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    ray_sphere_intersect_core dut (.*);

    ray_sphere_checker u_checker (.*);

    // Receiver: random stall, or a counted hold-off when requested
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(1023)) - 512);
            3: return 16'($signed($urandom_range(8191)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one ray beat; valid stays up until the next idle gap or drain
    task automatic send_ray(ray_in_t ray);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ray;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Write one register; the caller drops the write enable afterwards
    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic set_sphere(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                              logic [15:0] r);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_SPHERE_RADIUS, r);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly rays aimed back toward the coordinate origin
    function automatic ray_in_t random_ray();
        ray_in_t ray;
        ray.origin_x = pick_coord();
        ray.origin_y = pick_coord();
        ray.origin_z = pick_coord();
        if ($urandom_range(3) != 0) begin
            ray.dir_x = 16'($signed(16'($urandom_range(511))) - 256 - ray.origin_x / 8);
            ray.dir_y = 16'($signed(16'($urandom_range(511))) - 256 - ray.origin_y / 8);
            ray.dir_z = 16'($signed(16'($urandom_range(511))) - 256 - ray.origin_z / 8);
        end else begin
            ray.dir_x = pick_coord();
            ray.dir_y = pick_coord();
            ray.dir_z = pick_coord();
        end
        return ray;
    endfunction

    initial begin
        ray_in_t ray;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rays with reset sphere: unit sphere at origin
        send_ray('{16'h0000, 16'h0000, 16'hfc00, 16'h0000, 16'h0000, 16'h0100});
        send_ray('{16'h0100, 16'h0000, 16'hfc00, 16'h0000, 16'h0000, 16'h0100});
        send_ray('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_ray('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000});
        send_ray('{16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0100});
        send_ray('{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0001});
        send_ray('{16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0001});
        send_ray('{16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h8000});
        send_ray('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000});
        send_ray('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
        send_ray('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
        drain();

        // Extremes of the sphere registers
        set_sphere(16'h7fff, 16'h8000, 16'h0000, 16'h7fff);
        send_ray('{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000});
        send_ray('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0001});
        send_ray('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        drain();
        set_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_ray('{16'h0000, 16'h0000, 16'hff00, 16'h0000, 16'h0000, 16'h0100});
        send_ray('{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000});
        drain();

        // Random phases: sphere setting and idling vary per phase
        for (int phase = 0; phase < 8; phase++) begin
            set_sphere(pick_coord(), pick_coord(), pick_coord(),
                       (phase == 7) ? 16'h7fff : 16'($urandom_range(4095)));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (phase == 4) hold_off_cycles = 400;
            for (int n = 0; n < 205; n++) begin
                ray = random_ray();
                send_ray(ray);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[ray_sphere_intersect_core.f]
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_front.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/rsi_div.sv
hw/rtl/ray_sphere_intersect_core.sv
verif/ray_sphere_checker.sv
verif/tb_ray_sphere_intersect_core.sv
